@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Sizes, status codes and the entry/command structs used by the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY    = 64;
    localparam int SCORE_BITS  = 16;
    localparam int HANDLE_BITS = 16;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef struct packed {
        logic [SCORE_BITS-1:0]  score;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic                   push;
        logic                   pop;
        logic [SCORE_BITS-1:0]  score;
        logic [HANDLE_BITS-1:0] handle;
    } cmd_t;

endpackage

@@ design/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift chain
// Holds one entry; on push shifts right past the insertion point, on pop
// takes the entry of its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic   clk,
    input  cmd_t   cmd,
    input  logic   occ,
    input  entry_t left_entry,
    input  logic   left_move,
    input  entry_t right_entry,
    output entry_t entry,
    output logic   move
);

    entry_t entry_reg;
    entry_t entry_next;

    // slot is at or after the insertion point (strict > keeps ties in order)
    assign move  = !occ || (entry_reg.score > cmd.score);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push && move)
        begin
            if (left_move)
                entry_next = left_entry;
            else
                entry_next = '{score: cmd.score, handle: cmd.handle};
        end
        else if (cmd.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ design/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: min-first priority queue on a shift chain of cells
// Entries stay sorted by score in a row of cells; push and pop touch all
// cells at once.
// ----------------------------------------------------------------------------
// Result: done rises in the cycle after start is taken, with the result registered.
// Throughput: one transfer per cycle; every cell compares against the new
//   score in parallel and shifts one step, so busy stays low.
// Reset: rst_n clears the entry count and the result strobe; cell contents
//   are not cleared and are only read below the count.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   mode,
    input  logic [SCORE_BITS-1:0]  score,
    input  logic [HANDLE_BITS-1:0] node_handle,
    output logic                   done,
    output logic [1:0]             status,
    output logic [SCORE_BITS-1:0]  best_score,
    output logic [HANDLE_BITS-1:0] best_handle,
    output logic [COUNT_W-1:0]     entry_count
);

    // occupancy
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               full;
    logic               empty;

    // result register
    logic                   done_reg;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic [SCORE_BITS-1:0]  best_score_reg;
    logic [SCORE_BITS-1:0]  best_score_next;
    logic [HANDLE_BITS-1:0] best_handle_reg;
    logic [HANDLE_BITS-1:0] best_handle_next;

    cmd_t                 cmd;
    entry_t               cell_entry [CAPACITY];
    logic [CAPACITY-1:0]  cell_move;
    logic [CAPACITY-1:0]  cell_occ;

    // all cells act on an operation at once, so no backpressure is needed
    assign busy = 1'b0;

    assign full  = (count_reg == COUNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // rejected transfers (full push, empty pop) leave the cells untouched
    assign cmd.push   = start && !busy && (mode == MODE_PUSH) && !full;
    assign cmd.pop    = start && !busy && (mode == MODE_POP) && !empty;
    assign cmd.score  = score;
    assign cmd.handle = node_handle;

    // chain of cells; slot 0 always holds the lowest score
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_m;
            entry_t right_e;

            assign cell_occ[gi] = (count_reg > COUNT_W'(gi));

            if (gi == 0)
            begin : g_head
                assign left_e = '0;
                assign left_m = 1'b0;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign left_m = cell_move[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occ         (cell_occ[gi]),
                .left_entry  (left_e),
                .left_move   (left_m),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .move        (cell_move[gi])
            );
        end
    endgenerate

    // next count and result
    always_comb
    begin
        count_next       = count_reg;
        status_next      = status_reg;
        best_score_next  = best_score_reg;
        best_handle_next = best_handle_reg;
        if (start && !busy)
        begin
            best_score_next  = '0;
            best_handle_next = '0;
            if (mode == MODE_PUSH)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_PUSHED;
                    count_next  = count_reg + COUNT_W'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next      = ST_POPPED;
                    best_score_next  = cell_entry[0].score;
                    best_handle_next = cell_entry[0].handle;
                    count_next       = count_reg - COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        best_score_reg  <= best_score_next;
        best_handle_reg <= best_handle_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign best_score  = best_score_reg;
    assign best_handle = best_handle_reg;
    assign entry_count = count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted transfer gave no result");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_POP && !empty)
            |=> (entry_count == $past(count_reg) - COUNT_W'(1)))
        else $error("pop did not decrement count");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_occ[1] |-> (cell_entry[0].score <= cell_entry[1].score))
        else $error("head of queue out of order");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_priority_queue
// Pushes and pops go through the start/busy handshake. A scoreboard keeps
// its own sorted copy of the queue, works out status, popped entry and count
// for every accepted transfer, and checks each done strobe against them.
// ----------------------------------------------------------------------------
module testbench;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_LIMIT  = 200;

    // one expected result per accepted transfer
    typedef struct {
        logic [1:0]             status;
        logic [SCORE_BITS-1:0]  score;
        logic [HANDLE_BITS-1:0] handle;
        logic [COUNT_W-1:0]     count;
    } queue_result_t;

    // Scoreboard: a plain sorted array mirrors the queue. Ties go behind
    // every equal score, so equal scores leave in arrival order.
    class queue_scoreboard;
        entry_t        slots [CAPACITY];
        int            held;
        queue_result_t pending [$];
        int            errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        // Accepted transfer: update the mirror and queue up the outcome.
        function void note_command(input logic op, input logic [SCORE_BITS-1:0] s,
                                   input logic [HANDLE_BITS-1:0] h);
            queue_result_t r;
            int pos;
            r.score  = '0;
            r.handle = '0;
            if (op == MODE_PUSH) begin
                if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < held && slots[pos].score <= s)
                        pos++;
                    for (int i = held; i > pos; i--)
                        slots[i] = slots[i-1];
                    slots[pos].score  = s;
                    slots[pos].handle = h;
                    held++;
                    r.status = ST_PUSHED;
                end
            end else begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.score  = slots[0].score;
                    r.handle = slots[0].handle;
                    for (int i = 1; i < held; i++)
                        slots[i-1] = slots[i];
                    held--;
                    r.status = ST_POPPED;
                end
            end
            r.count = COUNT_W'(held);
            pending.push_back(r);
        endfunction

        // done strobe: compare field by field with the oldest expectation
        task check_result(input logic [1:0] st, input logic [SCORE_BITS-1:0] s,
                          input logic [HANDLE_BITS-1:0] h, input logic [COUNT_W-1:0] c);
            queue_result_t exp_r;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending (status %0d)", st));
                return;
            end
            exp_r = pending.pop_front();
            if (st !== exp_r.status)
                report($sformatf("status %0d, want %0d", st, exp_r.status));
            if (s !== exp_r.score)
                report($sformatf("best_score %h, want %h", s, exp_r.score));
            if (h !== exp_r.handle)
                report($sformatf("best_handle %h, want %h", h, exp_r.handle));
            if (c !== exp_r.count)
                report($sformatf("entry_count %0d, want %0d", c, exp_r.count));
        endtask

        task flush();
            while (pending.size() != 0) begin
                void'(pending.pop_front());
                report("expected result never arrived");
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   start       = 1'b0;
    logic                   mode        = MODE_PUSH;
    logic [SCORE_BITS-1:0]  score       = '0;
    logic [HANDLE_BITS-1:0] node_handle = '0;
    logic                   busy;
    logic                   done;
    logic [1:0]             status;
    logic [SCORE_BITS-1:0]  best_score;
    logic [HANDLE_BITS-1:0] best_handle;
    logic [COUNT_W-1:0]     entry_count;

    queue_scoreboard sb = new();
    int idle_pct = 0;    // chance, in percent, of an idle cycle before a transfer

    sorted_priority_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .score       (score),
        .node_handle (node_handle),
        .done        (done),
        .status      (status),
        .best_score  (best_score),
        .best_handle (best_handle),
        .entry_count (entry_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitor: everything is sampled at the rising edge, before the block's
    // own nonblocking updates land. The transfer is noted before the result
    // is checked, so even a result that comes in the same cycle as its transfer finds its expectation.
    always @(posedge clk) begin
        if (rst_n && start && !busy)
            sb.note_command(mode, score, node_handle);
        if (rst_n && done)
            sb.check_result(status, best_score, best_handle, entry_count);
    end

    // Scores: many from a tiny range to force ties, some at the extremes.
    function automatic logic [SCORE_BITS-1:0] pick_score();
        case ($urandom_range(7))
            0, 1:    return SCORE_BITS'($urandom_range(7));
            2:       return '0;
            3:       return '1;
            default: return SCORE_BITS'($urandom);
        endcase
    endfunction

    // One transfer. Random idle cycles come first, with start low and junk
    // on the payload. start is raised once and held until a non-busy edge;
    // back-to-back calls keep it high without lowering it in between.
    task automatic send_command(input logic op, input logic [SCORE_BITS-1:0] s,
                                input logic [HANDLE_BITS-1:0] h);
        while ($urandom_range(99) < idle_pct) begin
            start       <= 1'b0;
            mode        <= 1'($urandom);
            score       <= SCORE_BITS'($urandom);
            node_handle <= HANDLE_BITS'($urandom);
            @(posedge clk);
        end
        start       <= 1'b1;
        mode        <= op;
        score       <= s;
        node_handle <= h;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Pops carry junk in the ignored fields.
    task automatic send_pop();
        send_command(MODE_POP, SCORE_BITS'($urandom), HANDLE_BITS'($urandom));
    endtask

    initial begin
        int burst_len;
        int push_pct;
        int sent;
        int drain_cycles;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        idle_pct = 8;
        send_pop();                                  // pop on empty queue
        send_command(MODE_PUSH, '0, '0);             // lowest score
        send_command(MODE_PUSH, '1, '1);             // highest score
        send_command(MODE_PUSH, 16'h8000, 16'h0001); // three equal scores:
        send_command(MODE_PUSH, 16'h8000, 16'h0002); // must leave in
        send_command(MODE_PUSH, 16'h8000, 16'h0003); // arrival order
        send_command(MODE_PUSH, '0, '1);             // tie with the minimum
        repeat (7) send_pop();                       // drain, last one empty
        send_command(MODE_PUSH, 16'h1234, 16'haaaa);
        send_command(MODE_PUSH, 16'h1234, 16'h5555);
        send_pop();
        send_pop();

        // ---- random part ----
        // Bursts lean toward pushes or pops so the queue runs all the way
        // to full (dropped pushes) and back to empty (pops on empty).
        // Sender idling: light, then heavy, then none.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(20, 100);
            case ($urandom_range(3))
                0:       push_pct = 90;
                1:       push_pct = 10;
                default: push_pct = 50;
            endcase
            repeat (burst_len) begin
                if (sent < RANDOM_ITEMS / 3)
                    idle_pct = 8;
                else if (sent < 2 * RANDOM_ITEMS / 3)
                    idle_pct = 72;
                else
                    idle_pct = 0;
                if ($urandom_range(99) < push_pct)
                    send_command(MODE_PUSH, pick_score(), HANDLE_BITS'($urandom));
                else
                    send_pop();
                sent++;
            end
        end
        start <= 1'b0;

        // wait for the last results, bounded, then let the bench go quiet before the flush
        drain_cycles = 0;
        while (sb.pending.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (4) @(posedge clk);
        sb.flush();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
